### rtl/twpi_pkg.sv
// shared constants, types and tables of the tracking wheel pose integrator
package twpi_pkg;

  localparam int ANGLE_BITS  = 24;
  localparam int TRIG_STAGES = 20;
  localparam int ITER_W      = (TRIG_STAGES > 1) ? $clog2(TRIG_STAGES) : 1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_DIAM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORZ_DIAM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HORZ_OFS  = 3'd4;

  localparam logic [1:0] OP_BASELINE = 2'd0;
  localparam logic [1:0] OP_UPDATE   = 2'd1;
  localparam logic [1:0] OP_SET_POSE = 2'd2;

  localparam int TRAVEL_FRAC = 8;
  localparam int TRAV_W      = 44;
  localparam int DIFF_W      = TRAV_W + 1;
  localparam int CORR_W      = 62;
  localparam int CW          = 44;
  localparam int ZW          = 34;
  localparam int GW          = 36;
  localparam int LOCAL_EXP   = 40;

  localparam int MD_AW     = 49;
  localparam int MD_BW     = 34;
  localparam int DTH_SHIFT = 41 - ANGLE_BITS;
  localparam int MD_DW     = (17 + DTH_SHIFT > 40) ? 17 + DTH_SHIFT : 40;
  localparam int MD_PW     = ((MD_AW + MD_BW > MD_DW) ? MD_AW + MD_BW : MD_DW) + 1;
  localparam int MD_QW     = 64;
  localparam int MD_CNT_W  = $clog2(MD_PW);

  localparam logic [MD_BW-1:0] PI_Q32      = 34'd13493037705;
  localparam logic [MD_BW-1:0] INVPI_Q32   = 34'd1367130551;
  localparam logic [MD_BW-1:0] INVGAIN_Q31 = 34'd1304065748;
  localparam logic [MD_DW-1:0] TRAVEL_DIV  = MD_DW'(36000) << (32 - TRAVEL_FRAC);
  localparam logic [MD_DW-1:0] GAIN_DIV    = MD_DW'(1) << (31 + TRAVEL_FRAC);

  typedef struct packed {
    logic             start;
    logic [MD_AW-1:0] a;
    logic [MD_BW-1:0] b;
    logic [MD_DW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [MD_QW-1:0] q;
  } md_rsp_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/twpi_muldiv.sv
// bit-serial rounded scale unit: round(a*b/d), half away from zero
module twpi_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  twpi_pkg::md_req_t req,
  output twpi_pkg::md_rsp_t rsp
);

  typedef enum logic [4:0] {
    MD_IDLE = 5'b00001,
    MD_MUL  = 5'b00010,
    MD_RND  = 5'b00100,
    MD_DIV  = 5'b01000,
    MD_DONE = 5'b10000
  } md_state_t;

  md_state_t                        state_r;
  logic [twpi_pkg::MD_CNT_W-1:0]    cnt_r;
  logic                             neg_r;
  logic [twpi_pkg::MD_AW-1:0]       ua_r;
  logic [twpi_pkg::MD_BW-1:0]       b_r;
  logic [twpi_pkg::MD_DW-1:0]       d_r;
  logic [twpi_pkg::MD_PW-1:0]       p_r;
  logic [twpi_pkg::MD_DW-1:0]       r_r;
  logic [twpi_pkg::MD_QW-1:0]       q_r;

  logic [twpi_pkg::MD_AW-1:0]       ua_in;
  logic [twpi_pkg::MD_DW:0]         rs;
  logic [twpi_pkg::MD_DW:0]         rd;
  logic                             ge;

  assign ua_in = req.a[twpi_pkg::MD_AW-1] ? (~req.a + 1'b1) : req.a;
  assign rs    = {r_r, p_r[twpi_pkg::MD_PW-1]};
  assign rd    = rs - {1'b0, d_r};
  assign ge    = (rs >= {1'b0, d_r});

  assign rsp.done = (state_r == MD_DONE);
  assign rsp.q    = neg_r ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      case (state_r)
        MD_IDLE: begin
          if (req.start) begin
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (cnt_r == '0) begin
            state_r <= MD_RND;
          end
        end
        MD_RND: begin
          state_r <= MD_DIV;
        end
        MD_DIV: begin
          if (cnt_r == '0) begin
            state_r <= MD_DONE;
          end
        end
        MD_DONE: begin
          state_r <= MD_IDLE;
        end
        default: begin
          state_r <= MD_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        neg_r <= req.a[twpi_pkg::MD_AW-1];
        ua_r  <= ua_in;
        b_r   <= req.b;
        d_r   <= req.d;
        p_r   <= '0;
        r_r   <= '0;
        q_r   <= '0;
        cnt_r <= twpi_pkg::MD_CNT_W'(twpi_pkg::MD_BW - 1);
      end
      MD_MUL: begin
        p_r   <= {p_r[twpi_pkg::MD_PW-2:0], 1'b0} +
                 (b_r[twpi_pkg::MD_BW-1] ? twpi_pkg::MD_PW'(ua_r) : '0);
        b_r   <= {b_r[twpi_pkg::MD_BW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      MD_RND: begin
        p_r   <= p_r + twpi_pkg::MD_PW'(d_r >> 1);
        cnt_r <= twpi_pkg::MD_CNT_W'(twpi_pkg::MD_PW - 1);
      end
      MD_DIV: begin
        r_r   <= ge ? rd[twpi_pkg::MD_DW-1:0] : rs[twpi_pkg::MD_DW-1:0];
        q_r   <= {q_r[twpi_pkg::MD_QW-2:0], ge};
        p_r   <= {p_r[twpi_pkg::MD_PW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

### rtl/tracking_wheel_pose_integrator.sv
// top level of the three tracking wheel pose integrator
// One result item per input item, the pose after that item. Baseline, set-pose
// and unused opcodes go straight to the output. An update runs seven passes
// through one bit-serial multiply-divide unit (wheel travel three times, heading
// change, offset correction, gain removal for x and y) and 20 rotation stages;
// the heading change and offset correction passes are skipped when both
// vertical offsets are zero. One item is in work at a time; configuration
// writes are taken at any cycle and belong only between items.
module tracking_wheel_pose_integrator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // left_cdeg, right_cdeg, side_cdeg, new_x, new_y, new_heading
  input  logic [((160+twpi_pkg::ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  // op
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // pos_x, pos_y, heading_angle
  output logic [((64+twpi_pkg::ANGLE_BITS+7)/8)*8-1:0]  out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [twpi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int AB  = twpi_pkg::ANGLE_BITS;
  localparam int OTW = ((64 + AB + 7) / 8) * 8;
  localparam logic signed [62:0] LIM = 63'sd1 <<< twpi_pkg::LOCAL_EXP;
  localparam logic signed [twpi_pkg::ZW-1:0] Z_QTR  = twpi_pkg::ZW'(1) <<< 30;
  localparam logic signed [twpi_pkg::ZW-1:0] Z_HALF = twpi_pkg::ZW'(1) <<< 31;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TRAV  = 9'b000000010,
    S_DTH   = 9'b000000100,
    S_CORR  = 9'b000001000,
    S_LOCAL = 9'b000010000,
    S_ROT   = 9'b000100000,
    S_GAIN  = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r;
  logic   run_r;
  logic [1:0] widx_r;
  logic       gidx_r;
  logic [twpi_pkg::ITER_W-1:0] iter_r;

  logic [15:0] vd_r, hd_r, lo_r, ro_r, ho_r;
  logic [31:0] last_l_r, last_r_r, last_s_r;
  logic [31:0] cur_l_r, cur_r_r, cur_s_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic [AB-1:0] acc_h_r;

  logic signed [twpi_pkg::TRAV_W-1:0] tl_r, tr_r, ts_r;
  logic [AB:0] dth_r;
  logic signed [twpi_pkg::CORR_W-1:0] corr_r;
  logic signed [twpi_pkg::CW-1:0] cx_r, cy_r;
  logic signed [twpi_pkg::ZW-1:0] cz_r;
  logic signed [twpi_pkg::GW-1:0] gx_r, gy_r;

  logic                  out_valid_r;
  logic [OTW-1:0]        out_data_r;

  twpi_pkg::md_req_t req;
  twpi_pkg::md_rsp_t rsp;
  logic                          req_start_r;
  logic [twpi_pkg::MD_AW-1:0]    req_a_r;
  logic [twpi_pkg::MD_BW-1:0]    req_b_r;
  logic [twpi_pkg::MD_DW-1:0]    req_d_r;

  logic [31:0] delta_w;
  logic [15:0] diam_w;
  logic signed [48:0] trav_prod;
  logic [15:0] lo_abs, ro_abs, ho_abs;
  logic [16:0] width_w;
  logic signed [twpi_pkg::DIFF_W-1:0] diff_w;
  logic signed [twpi_pkg::CORR_W-1:0] corr_q;
  logic signed [62:0] dx_full, dy_full;
  logic signed [twpi_pkg::CW-1:0] dx_c, dy_c;
  logic [AB-1:0] midang;
  logic [31:0] z32;
  logic signed [twpi_pkg::ZW-1:0] z0;
  logic signed [twpi_pkg::CW-1:0] xs, ys;
  logic signed [twpi_pkg::ZW-1:0] atn;
  logic signed [36:0] sum_x, sum_y;
  logic signed [31:0] sat_x, sat_y;
  logic accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign req.start = req_start_r;
  assign req.a     = req_a_r;
  assign req.b     = req_b_r;
  assign req.d     = req_d_r;

  twpi_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  function automatic logic signed [twpi_pkg::CW-1:0] clamp_loc(input logic signed [62:0] v);
    logic signed [62:0] c;
    c = v;
    if (v > LIM) begin
      c = LIM;
    end else if (v < -LIM) begin
      c = -LIM;
    end
    return c[twpi_pkg::CW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] s;
    s = v[31:0];
    if (v > 37'sd2147483647) begin
      s = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      s = 32'sh80000000;
    end
    return s;
  endfunction

  always_comb begin
    case (widx_r)
      2'd0:    begin delta_w = cur_l_r - last_l_r; diam_w = vd_r; end
      2'd1:    begin delta_w = cur_r_r - last_r_r; diam_w = vd_r; end
      default: begin delta_w = cur_s_r - last_s_r; diam_w = hd_r; end
    endcase
  end

  assign trav_prod = $signed(delta_w) * $signed({1'b0, diam_w});
  assign lo_abs    = lo_r[15] ? (~lo_r + 1'b1) : lo_r;
  assign ro_abs    = ro_r[15] ? (~ro_r + 1'b1) : ro_r;
  assign ho_abs    = ho_r[15] ? (~ho_r + 1'b1) : ho_r;
  assign width_w   = {1'b0, lo_abs} + {1'b0, ro_abs};
  assign diff_w    = twpi_pkg::DIFF_W'(tr_r) - twpi_pkg::DIFF_W'(tl_r);
  assign corr_q    = ho_r[15] ? -$signed(rsp.q[twpi_pkg::CORR_W-1:0])
                              : $signed(rsp.q[twpi_pkg::CORR_W-1:0]);

  assign dx_full = 63'(ts_r) - 63'(corr_r);
  assign dy_full = 63'((twpi_pkg::DIFF_W'(tl_r) + twpi_pkg::DIFF_W'(tr_r)) >>> 1);
  assign dx_c    = clamp_loc(dx_full);
  assign dy_c    = clamp_loc(dy_full);

  assign midang = acc_h_r + dth_r[AB:1];
  assign z32    = 32'(midang) << (32 - AB);
  assign z0     = twpi_pkg::ZW'($signed(z32));

  assign xs  = cx_r >>> iter_r;
  assign ys  = cy_r >>> iter_r;
  assign atn = $signed(twpi_pkg::ZW'(twpi_pkg::atan_val(5'(iter_r))));

  assign sum_x = 37'(acc_x_r) + 37'(gx_r);
  assign sum_y = 37'(acc_y_r) + 37'(gy_r);
  assign sat_x = sat32(sum_x);
  assign sat_y = sat32(sum_y);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 16'd2816;
      hd_r <= 16'd2816;
      lo_r <= 16'd5120;
      ro_r <= 16'd5120;
      ho_r <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        twpi_pkg::CFG_VERT_DIAM: vd_r <= cfg_data;
        twpi_pkg::CFG_HORZ_DIAM: hd_r <= cfg_data;
        twpi_pkg::CFG_LEFT_OFS:  lo_r <= cfg_data;
        twpi_pkg::CFG_RIGHT_OFS: ro_r <= cfg_data;
        twpi_pkg::CFG_HORZ_OFS:  ho_r <= cfg_data;
        default:                 vd_r <= vd_r;
      endcase
    end
  end

  // sequencer and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      req_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      last_s_r    <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
    end else begin
      if (req_start_r) begin
        req_start_r <= 1'b0;
      end
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cur_l_r <= in_tdata[31:0];
            cur_r_r <= in_tdata[63:32];
            cur_s_r <= in_tdata[95:64];
            widx_r  <= 2'd0;
            case (in_tuser)
              twpi_pkg::OP_BASELINE: begin
                last_l_r <= in_tdata[31:0];
                last_r_r <= in_tdata[63:32];
                last_s_r <= in_tdata[95:64];
                state_r  <= S_OUT;
              end
              twpi_pkg::OP_UPDATE: begin
                state_r <= S_TRAV;
              end
              twpi_pkg::OP_SET_POSE: begin
                acc_x_r <= in_tdata[127:96];
                acc_y_r <= in_tdata[159:128];
                acc_h_r <= in_tdata[160 +: AB];
                state_r <= S_OUT;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_TRAV: begin
          if (!run_r) begin
            req_a_r     <= trav_prod;
            req_b_r     <= twpi_pkg::PI_Q32;
            req_d_r     <= twpi_pkg::TRAVEL_DIV;
            req_start_r <= 1'b1;
            run_r       <= 1'b1;
          end else if (rsp.done) begin
            run_r <= 1'b0;
            case (widx_r)
              2'd0:    tl_r <= rsp.q[twpi_pkg::TRAV_W-1:0];
              2'd1:    tr_r <= rsp.q[twpi_pkg::TRAV_W-1:0];
              default: ts_r <= rsp.q[twpi_pkg::TRAV_W-1:0];
            endcase
            if (widx_r == 2'd2) begin
              state_r <= S_DTH;
            end else begin
              widx_r <= widx_r + 1'b1;
            end
          end
        end
        S_DTH: begin
          if (width_w == '0) begin
            dth_r   <= '0;
            corr_r  <= '0;
            state_r <= S_LOCAL;
          end else if (!run_r) begin
            req_a_r     <= twpi_pkg::MD_AW'(diff_w);
            req_b_r     <= twpi_pkg::INVPI_Q32;
            req_d_r     <= twpi_pkg::MD_DW'(width_w) << twpi_pkg::DTH_SHIFT;
            req_start_r <= 1'b1;
            run_r       <= 1'b1;
          end else if (rsp.done) begin
            run_r   <= 1'b0;
            dth_r   <= rsp.q[AB:0];
            state_r <= S_CORR;
          end
        end
        S_CORR: begin
          if (!run_r) begin
            req_a_r     <= twpi_pkg::MD_AW'(diff_w);
            req_b_r     <= twpi_pkg::MD_BW'(ho_abs);
            req_d_r     <= twpi_pkg::MD_DW'(width_w);
            req_start_r <= 1'b1;
            run_r       <= 1'b1;
          end else if (rsp.done) begin
            run_r   <= 1'b0;
            corr_r  <= corr_q;
            state_r <= S_LOCAL;
          end
        end
        S_LOCAL: begin
          acc_h_r <= acc_h_r + dth_r[AB-1:0];
          iter_r  <= '0;
          if (z0 > Z_QTR) begin
            cz_r <= z0 - Z_HALF;
            cx_r <= -dx_c;
            cy_r <= -dy_c;
          end else if (z0 < -Z_QTR) begin
            cz_r <= z0 + Z_HALF;
            cx_r <= -dx_c;
            cy_r <= -dy_c;
          end else begin
            cz_r <= z0;
            cx_r <= dx_c;
            cy_r <= dy_c;
          end
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - atn;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + atn;
          end
          iter_r <= iter_r + 1'b1;
          if (iter_r == twpi_pkg::ITER_W'(twpi_pkg::TRIG_STAGES - 1)) begin
            gidx_r  <= 1'b0;
            state_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (!run_r) begin
            req_a_r     <= gidx_r ? twpi_pkg::MD_AW'(cy_r) : twpi_pkg::MD_AW'(cx_r);
            req_b_r     <= twpi_pkg::INVGAIN_Q31;
            req_d_r     <= twpi_pkg::GAIN_DIV;
            req_start_r <= 1'b1;
            run_r       <= 1'b1;
          end else if (rsp.done) begin
            run_r <= 1'b0;
            if (gidx_r) begin
              gy_r    <= rsp.q[twpi_pkg::GW-1:0];
              state_r <= S_SUM;
            end else begin
              gx_r   <= rsp.q[twpi_pkg::GW-1:0];
              gidx_r <= 1'b1;
            end
          end
        end
        S_SUM: begin
          acc_x_r  <= sat_x;
          acc_y_r  <= sat_y;
          last_l_r <= cur_l_r;
          last_r_r <= cur_r_r;
          last_s_r <= cur_s_r;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OTW'({acc_h_r, acc_y_r, acc_x_r});
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
